// ===== hdl/lpcm_pkg.sv =====
// Shared constants, types and the sample decoder of the linear PCM rate converter.
package lpcm_pkg;

	localparam int MAX_STEP       = 64;
	localparam int MAX_OUT_PER_IN = 64;
	localparam int STEP_W         = 7;
	localparam int CNT_W          = 7;
	localparam int DEN_W          = 16;
	localparam int FRAC_W         = 17;
	localparam int SMP_W          = 16;
	localparam int PSUM_W         = 24;
	localparam int PROD_W         = 33;
	localparam int VAL_W          = 25;
	localparam int DIV_W          = 32;
	localparam int DIV_CNT_W      = 5;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int NUM_CH         = 2;
	localparam int CH_L           = 0;
	localparam int CH_R           = 1;

	localparam logic [SMP_W-1:0] SAMPLE_BIAS = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_WHOLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_NUM      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DEN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT        = 3'd6;

	localparam logic [1:0] LAYOUT_LR = 2'd1;
	localparam logic [1:0] LAYOUT_RL = 2'd2;

	typedef struct packed {
		logic load_frame;
		logic prime;
		logic begin_out;
		logic consume;
		logic mul_new;
		logic mul_old;
		logic div1_start;
		logic latch_q1;
		logic div2_start;
		logic result;
		logic skip_start;
		logic skip_apply;
		logic emit;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic primed;
		logic steps_zero;
		logic begin_zero;
		logic num_zero;
		logic consume_last;
		logic steps_gt1;
		logic div_done;
		logic slot_free;
		logic pend_valid;
	} stat_t;

	// Turns the two stored bytes of one channel into a signed 16-bit scale sample.
	function automatic logic signed [SMP_W-1:0] decode_sample(input logic [15:0] bytes,
		input logic wide, input logic uns, input logic le);
		logic [SMP_W-1:0] raw;
		if (!wide) begin
			raw = {bytes[7:0], 8'h00};
		end else if (le) begin
			raw = bytes;
		end else begin
			raw = {bytes[7:0], bytes[15:8]};
		end
		if (uns) begin
			raw = raw ^ SAMPLE_BIAS;
		end
		return $signed(raw);
	endfunction

endpackage

// ===== hdl/lpcm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module lpcm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lpcm_pkg::DIV_W-1:0]       dividend,
	input  logic [lpcm_pkg::DEN_W-1:0]       divisor,
	output logic                             done,
	output logic [lpcm_pkg::DIV_W-1:0]       quotient,
	output logic [lpcm_pkg::DEN_W-1:0]       remainder
);
	import lpcm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     dvs_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/lpcm_dp.sv =====
// Datapath: configuration, sample state, interpolation arithmetic and result staging.
module lpcm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [lpcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lpcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [15:0]                         first_channel_bytes,
	input  logic [15:0]                         second_channel_bytes,
	input  lpcm_pkg::cmd_t                      cmd,
	output lpcm_pkg::stat_t                     stat,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [lpcm_pkg::SMP_W-1:0]   left_out,
	output logic signed [lpcm_pkg::SMP_W-1:0]   right_out,
	output logic                                last_of_run
);
	import lpcm_pkg::*;

	// Configuration registers.
	logic [STEP_W-1:0] whole_q;
	logic [DEN_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic              wide_q;
	logic              uns_q;
	logic              le_q;
	logic [1:0]        layout_q;

	// Stream state.
	logic signed [SMP_W-1:0]  frame_q [NUM_CH];
	logic signed [SMP_W-1:0]  older_q [NUM_CH];
	logic signed [SMP_W-1:0]  newer_q [NUM_CH];
	logic signed [PSUM_W-1:0] psum_q  [NUM_CH];
	logic [FRAC_W-1:0]        frac_q;
	logic [STEP_W-1:0]        need_q;
	logic [STEP_W-1:0]        done_q;
	logic                     primed_q;

	// Arithmetic staging.
	logic signed [PROD_W-1:0] pn_q    [NUM_CH];
	logic signed [PROD_W-1:0] acc_q   [NUM_CH];
	logic                     sign1_q [NUM_CH];
	logic signed [VAL_W-1:0]  v_q     [NUM_CH];
	logic                     sign2_q [NUM_CH];
	logic [SMP_W-1:0]         res_q   [NUM_CH];
	logic [SMP_W-1:0]         pend_q  [NUM_CH];
	logic                     pend_valid_q;

	// Output register.
	logic                     out_valid_q;
	logic [SMP_W-1:0]         out_q [NUM_CH];
	logic                     last_q;

	logic [DEN_W-1:0]         den_eff;
	logic [DEN_W-1:0]         num_eff;
	logic [STEP_W-1:0]        whole_eff;
	logic                     carry;
	logic [FRAC_W-1:0]        frac_a;
	logic [FRAC_W-1:0]        frac_b;
	logic [STEP_W-1:0]        s_next;
	logic [DEN_W-1:0]         f;
	logic signed [DEN_W:0]    fs;
	logic signed [DEN_W:0]    dmfs;
	logic [FRAC_W:0]          skip_x;
	logic [FRAC_W:0]          skip_frac;
	logic signed [SMP_W-1:0]  dec_first;
	logic signed [SMP_W-1:0]  dec_second;
	logic signed [SMP_W-1:0]  fl;
	logic signed [SMP_W-1:0]  fr;
	logic [PROD_W-1:0]        acc_abs [NUM_CH];
	logic [VAL_W-1:0]         v_abs   [NUM_CH];
	logic signed [FRAC_W:0]   q1s     [NUM_CH];
	logic [SMP_W-1:0]         q2      [NUM_CH];
	logic [DIV_W-1:0]         dvd     [NUM_CH];
	logic [DEN_W-1:0]         dvs     [NUM_CH];
	logic [NUM_CH-1:0]        div_go;
	logic [NUM_CH-1:0]        div_done;
	logic [DIV_W-1:0]         quo     [NUM_CH];
	logic [DEN_W-1:0]         rem     [NUM_CH];
	logic                     slot_free;
	logic                     out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q  <= STEP_W'(1);
			num_q    <= '0;
			den_q    <= DEN_W'(1);
			wide_q   <= 1'b1;
			uns_q    <= 1'b0;
			le_q     <= 1'b1;
			layout_q <= LAYOUT_LR;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_STEP_WHOLE:    whole_q  <= cfg_data[STEP_W-1:0];
				REG_STEP_NUM:      num_q    <= cfg_data;
				REG_STEP_DEN:      den_q    <= cfg_data;
				REG_WIDE:          wide_q   <= cfg_data[0];
				REG_UNSIGNED:      uns_q    <= cfg_data[0];
				REG_LITTLE_ENDIAN: le_q     <= cfg_data[0];
				REG_LAYOUT:        layout_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		den_eff   = (den_q == '0) ? DEN_W'(1) : den_q;
		num_eff   = (num_q >= den_eff) ? den_eff - 1'b1 : num_q;
		whole_eff = (whole_q > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : whole_q;
		carry     = frac_q >= {1'b0, den_eff};
		frac_a    = carry ? frac_q - {1'b0, den_eff} : frac_q;
		frac_b    = (frac_a >= {1'b0, den_eff}) ? {1'b0, den_eff - 1'b1} : frac_a;
		s_next    = whole_eff + STEP_W'(carry);
		f         = (frac_q < {1'b0, den_eff}) ? frac_q[DEN_W-1:0] : den_eff - 1'b1;
		fs        = $signed({1'b0, f});
		dmfs      = $signed({1'b0, den_eff - f});
		skip_x    = {2'b00, den_eff} + {2'b00, num_eff} - (FRAC_W+1)'(1) - {1'b0, frac_q};
		skip_frac = {2'b00, den_eff} + {2'b00, num_eff} - (FRAC_W+1)'(1)
			- {2'b00, rem[CH_L]};
	end

	always_comb begin
		dec_first  = decode_sample(first_channel_bytes, wide_q, uns_q, le_q);
		dec_second = decode_sample(second_channel_bytes, wide_q, uns_q, le_q);
		unique case (layout_q)
			LAYOUT_LR: begin
				fl = dec_first;
				fr = dec_second;
			end
			LAYOUT_RL: begin
				fl = dec_second;
				fr = dec_first;
			end
			default: begin
				fl = dec_first;
				fr = dec_first;
			end
		endcase
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			acc_abs[c] = acc_q[c][PROD_W-1] ? PROD_W'(-acc_q[c]) : PROD_W'(acc_q[c]);
			v_abs[c]   = v_q[c][VAL_W-1] ? VAL_W'(-v_q[c]) : VAL_W'(v_q[c]);
			q1s[c]     = sign1_q[c] ? -$signed({1'b0, quo[c][DEN_W:0]})
				: $signed({1'b0, quo[c][DEN_W:0]});
			q2[c]      = sign2_q[c] ? SMP_W'(-quo[c][SMP_W-1:0]) : quo[c][SMP_W-1:0];
			if (cmd.skip_start) begin
				dvd[c] = DIV_W'(skip_x);
				dvs[c] = num_eff;
			end else if (cmd.div2_start) begin
				dvd[c] = DIV_W'(v_abs[c]);
				dvs[c] = DEN_W'(need_q);
			end else begin
				dvd[c] = acc_abs[c][DIV_W-1:0];
				dvs[c] = den_eff;
			end
		end
	end

	for (genvar g = 0; g < NUM_CH; g++) begin : g_div
		if (g == CH_L) begin : g_shared
			assign div_go[g] = cmd.div1_start | cmd.div2_start | cmd.skip_start;
		end else begin : g_plain
			assign div_go[g] = cmd.div1_start | cmd.div2_start;
		end
		lpcm_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.start     (div_go[g]),
			.dividend  (dvd[g]),
			.divisor   (dvs[g]),
			.done      (div_done[g]),
			.quotient  (quo[g]),
			.remainder (rem[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			frac_q   <= '0;
			need_q   <= '0;
			done_q   <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				older_q[c] <= '0;
				newer_q[c] <= '0;
				psum_q[c]  <= '0;
			end
		end else begin
			if (cmd.prime) begin
				primed_q   <= 1'b1;
				older_q[CH_L] <= frame_q[CH_L];
				older_q[CH_R] <= frame_q[CH_R];
				newer_q[CH_L] <= frame_q[CH_L];
				newer_q[CH_R] <= frame_q[CH_R];
			end
			if (cmd.begin_out) begin
				frac_q <= frac_b;
				need_q <= s_next;
				done_q <= '0;
				for (int c = 0; c < NUM_CH; c++) begin
					psum_q[c] <= '0;
					if (s_next != '0) begin
						older_q[c] <= newer_q[c];
					end
				end
			end
			if (cmd.consume) begin
				done_q <= done_q + 1'b1;
				for (int c = 0; c < NUM_CH; c++) begin
					newer_q[c] <= frame_q[c];
					if ({1'b0, done_q} + (STEP_W+1)'(1) < {1'b0, need_q}) begin
						psum_q[c] <= psum_q[c] + PSUM_W'(frame_q[c]);
					end
				end
			end
			if (cmd.result) begin
				frac_q <= {1'b0, f} + {1'b0, num_eff};
			end
			if (cmd.skip_apply) begin
				frac_q <= skip_frac[FRAC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			frame_q[CH_L] <= fl;
			frame_q[CH_R] <= fr;
		end
		for (int c = 0; c < NUM_CH; c++) begin
			if (cmd.mul_new) begin
				pn_q[c] <= newer_q[c] * fs;
			end
			if (cmd.mul_old) begin
				acc_q[c] <= pn_q[c] + older_q[c] * dmfs;
			end
			if (cmd.div1_start) begin
				sign1_q[c] <= acc_q[c][PROD_W-1];
			end
			if (cmd.latch_q1) begin
				v_q[c] <= VAL_W'(q1s[c]) + VAL_W'(psum_q[c]);
			end
			if (cmd.div2_start) begin
				sign2_q[c] <= v_q[c][VAL_W-1];
			end
			if (cmd.result) begin
				res_q[c] <= (need_q > STEP_W'(1)) ? q2[c] : v_q[c][SMP_W-1:0];
			end
			if (cmd.emit) begin
				pend_q[c] <= res_q[c];
			end
			if (out_load) begin
				out_q[c] <= pend_q[c];
			end
		end
		if (out_load) begin
			last_q <= cmd.flush;
		end
	end

	assign slot_free = !out_valid_q || out_ready;
	assign out_load  = (cmd.emit && pend_valid_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.primed       = primed_q;
		stat.steps_zero   = need_q == '0;
		stat.begin_zero   = s_next == '0;
		stat.num_zero     = num_eff == '0;
		stat.consume_last = {1'b0, done_q} + (STEP_W+1)'(1) >= {1'b0, need_q};
		stat.steps_gt1    = need_q > STEP_W'(1);
		stat.div_done     = div_done[CH_L];
		stat.slot_free    = slot_free;
		stat.pend_valid   = pend_valid_q;
	end

	assign out_valid   = out_valid_q;
	assign left_out    = $signed(out_q[CH_L]);
	assign right_out   = $signed(out_q[CH_R]);
	assign last_of_run = last_q;

endmodule

// ===== hdl/lpcm_ctrl.sv =====
// Controller state machine that sequences priming, stepping, interpolation and output.
module lpcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpcm_pkg::stat_t   stat,
	output lpcm_pkg::cmd_t    cmd
);
	import lpcm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PRIME, S_BEGIN, S_CONSUME, S_MUL1, S_MUL2, S_DIV1S, S_DIV1W,
		S_DIV2S, S_DIV2W, S_RESULT, S_EMIT, S_SKIPS, S_SKIPW, S_END
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             frame_pend_q;
	logic             cap;

	assign cap      = count_q >= CNT_W'(MAX_OUT_PER_IN);
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.load_frame = in_valid;
			S_PRIME:   cmd.prime      = 1'b1;
			S_BEGIN:   cmd.begin_out  = 1'b1;
			S_CONSUME: cmd.consume    = 1'b1;
			S_MUL1:    cmd.mul_new    = 1'b1;
			S_MUL2:    cmd.mul_old    = 1'b1;
			S_DIV1S:   cmd.div1_start = 1'b1;
			S_DIV1W:   cmd.latch_q1   = stat.div_done;
			S_DIV2S:   cmd.div2_start = 1'b1;
			S_DIV2W:   ;
			S_RESULT:  cmd.result     = 1'b1;
			S_EMIT:    cmd.emit       = !stat.pend_valid || stat.slot_free;
			S_SKIPS:   cmd.skip_start = 1'b1;
			S_SKIPW:   cmd.skip_apply = stat.div_done;
			S_END:     cmd.flush      = stat.pend_valid && stat.slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			frame_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						count_q      <= '0;
						frame_pend_q <= stat.primed && stat.steps_zero;
						if (!stat.primed) begin
							state_q <= S_PRIME;
						end else if (stat.steps_zero) begin
							state_q <= S_BEGIN;
						end else begin
							state_q <= S_CONSUME;
						end
					end
				end
				S_PRIME: state_q <= S_BEGIN;
				S_BEGIN: begin
					if (!stat.begin_zero) begin
						state_q <= frame_pend_q ? S_CONSUME : S_END;
					end else if (!cap) begin
						state_q <= S_MUL1;
					end else if (stat.num_zero) begin
						state_q <= S_END;
					end else begin
						state_q <= S_SKIPS;
					end
				end
				S_CONSUME: begin
					frame_pend_q <= 1'b0;
					state_q      <= stat.consume_last ? S_MUL1 : S_END;
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_DIV1S;
				S_DIV1S: state_q <= S_DIV1W;
				S_DIV1W: begin
					if (stat.div_done) begin
						state_q <= stat.steps_gt1 ? S_DIV2S : S_RESULT;
					end
				end
				S_DIV2S: state_q <= S_DIV2W;
				S_DIV2W: begin
					if (stat.div_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: state_q <= cap ? S_BEGIN : S_EMIT;
				S_EMIT: begin
					if (cmd.emit) begin
						count_q <= count_q + 1'b1;
						state_q <= S_BEGIN;
					end
				end
				S_SKIPS: state_q <= S_SKIPW;
				S_SKIPW: begin
					if (stat.div_done) begin
						state_q <= S_BEGIN;
					end
				end
				S_END: begin
					if (!stat.pend_valid || cmd.flush) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_OUT_PER_IN))
		else $error("result count exceeded the per-request cap");

	a_emit_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !cap)
		else $error("result staged after the per-request cap");

	a_emit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> count_q == $past(count_q) + 1'b1)
		else $error("staged result was not counted");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.pend_valid)
		else $error("a staged result is still held while idle");

endmodule

// ===== hdl/linear_pcm_rate_converter.sv =====
// Top level of the linear interpolation PCM sample rate converter.
// One request is taken at a time; in_ready is high only while the block is idle.
// A request that only advances the step counter passes the consume and end states;
// each result runs the radix-2 dividers by the denominator and, when it averages more
// than one step, by the step count; results past the cap are skipped by a division by the numerator.
// Reset clears the stream state but the held frame, and loads the default ratio of one
// with stereo 16-bit little-endian signed samples; the first request after reset primes the stream.
module linear_pcm_rate_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [lpcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lpcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [15:0]                         first_channel_bytes,
	input  logic [15:0]                         second_channel_bytes,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lpcm_pkg::SMP_W-1:0]   left_out,
	output logic signed [lpcm_pkg::SMP_W-1:0]   right_out,
	output logic                                last_of_run
);
	import lpcm_pkg::*;

	// The controller issues one command group per cycle and reads back status.
	cmd_t  cmd;
	stat_t stat;

	// The controller walks each request through priming, stepping and the
	// interpolation sequence, and decides when a result leaves the block.
	lpcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the sample history, the per-channel
	// multipliers and dividers, and a one-deep staging register that lets the
	// last result of a request be marked before it is released.
	lpcm_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_write            (cfg_write),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.first_channel_bytes  (first_channel_bytes),
		.second_channel_bytes (second_channel_bytes),
		.cmd                  (cmd),
		.stat                 (stat),
		.out_ready            (out_ready),
		.out_valid            (out_valid),
		.left_out             (left_out),
		.right_out            (right_out),
		.last_of_run          (last_of_run)
	);

endmodule

// ===== tb/sv/tb_linear_pcm_rate_converter.sv =====
// Self-checking testbench of the linear PCM rate converter: directed table, random phases.
`timescale 1ns / 100ps

module tb_linear_pcm_rate_converter;
	import lpcm_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 200;
	localparam int HOLD_CYCLES    = 600;
	localparam int RANDOM_PHASES  = 8;
	localparam int RANDOM_ITEMS   = 150;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} frame_t;

	// One row of the directed table: register set, payload and, where it is
	// obvious, the single frame it must produce.
	typedef struct {
		int          cfg_sel;
		logic [15:0] first;
		logic [15:0] second;
		logic        has_exp;
		frame_t      exp;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [15:0]           first_channel_bytes;
	logic [15:0]           second_channel_bytes;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [15:0]    left_out;
	logic signed [15:0]    right_out;
	logic                  last_of_run;

	// Typed expectation that travels with the request, held like the payload.
	logic                  row_has_exp;
	frame_t                row_exp;

	linear_pcm_rate_converter dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_write            (cfg_write),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.first_channel_bytes  (first_channel_bytes),
		.second_channel_bytes (second_channel_bytes),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.left_out             (left_out),
		.right_out            (right_out),
		.last_of_run          (last_of_run)
	);

	// 4 ns clock.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Shadow copy of the registers as the converter should hold them.
	longint sh_whole, sh_num, sh_den, sh_wide, sh_uns, sh_le, sh_layout;

	// Stream state of the resampler as predicted.
	longint older_l, older_r, newer_l, newer_r, psum_l, psum_r;
	longint frac_acc, steps_need, steps_done;
	bit     stream_primed;

	frame_t frames_due[$];
	int     errors;
	int     results_seen;
	int     idle_cycles;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic longint den_eff();
		return (sh_den == 0) ? 1 : sh_den;
	endfunction

	function automatic longint num_eff();
		longint d;
		d = den_eff();
		return (sh_num >= d) ? d - 1 : sh_num;
	endfunction

	function automatic longint whole_eff();
		return (sh_whole > MAX_STEP) ? MAX_STEP : sh_whole;
	endfunction

	// Bytes of one channel to a signed sample on the 16-bit scale.
	function automatic longint decode_bytes(input logic [15:0] b);
		longint      b0;
		logic [15:0] raw;
		b0 = b[7:0];
		if (!sh_wide) begin
			if (sh_uns)
				return b0 * 256 - 32768;
			return longint'($signed(b[7:0])) * 256;
		end
		raw = sh_le ? b : {b[7:0], b[15:8]};
		if (sh_uns)
			return longint'(raw) - 32768;
		return longint'($signed(raw));
	endfunction

	function automatic void start_frame();
		longint d, s;
		d = den_eff();
		s = whole_eff();
		if (frac_acc >= d) begin
			frac_acc -= d;
			s++;
		end
		if (frac_acc >= d)
			frac_acc = d - 1;
		steps_need = s;
		steps_done = 0;
		psum_l = 0;
		psum_r = 0;
		if (s > 0) begin
			older_l = newer_l;
			older_r = newer_r;
		end
	endfunction

	function automatic longint blend(input longint o, input longint n, input longint p,
		input longint f, input longint d);
		longint v;
		// SystemVerilog division of signed operands truncates toward zero.
		v = (n * f + o * (d - f)) / d;
		v += p;
		if (steps_need > 1)
			v = v / steps_need;
		return v;
	endfunction

	function automatic void close_frame(output longint l, output longint r);
		longint d, f;
		d = den_eff();
		f = (frac_acc < d) ? frac_acc : d - 1;
		l = blend(older_l, newer_l, psum_l, f, d);
		r = blend(older_r, newer_r, psum_r, f, d);
		frac_acc = f + num_eff();
	endfunction

	function automatic void push_frame(inout int count, input longint l, input longint r);
		frame_t fr;
		fr.left = l[15:0];
		fr.right = r[15:0];
		fr.last = 1'b0;
		frames_due.push_back(fr);
		count++;
	endfunction

	// Starts outputs until one waits for a source frame or nothing more can come out.
	function automatic void run_frames(inout int count);
		longint l, r, n, d, k;
		forever begin
			start_frame();
			if (steps_need > 0)
				return;
			if (count < MAX_OUT_PER_IN) begin
				close_frame(l, r);
				push_frame(count, l, r);
			end else begin
				n = num_eff();
				d = den_eff();
				if (n == 0)
					return;
				k = (d - frac_acc + n - 1) / n;
				frac_acc += k * n;
			end
		end
	endfunction

	// Expected output frames of one accepted request; returns how many.
	function automatic int predict_frames(input logic [15:0] a, input logic [15:0] b);
		int     count;
		longint s1, s2, fl, fr, l, r;
		count = 0;
		s1 = decode_bytes(a);
		s2 = decode_bytes(b);
		if (sh_layout == LAYOUT_LR) begin
			fl = s1;
			fr = s2;
		end else if (sh_layout == LAYOUT_RL) begin
			fl = s2;
			fr = s1;
		end else begin
			fl = s1;
			fr = s1;
		end
		if (!stream_primed) begin
			newer_l = fl;
			older_l = fl;
			newer_r = fr;
			older_r = fr;
			stream_primed = 1'b1;
			run_frames(count);
		end else begin
			if (steps_need == 0)
				run_frames(count);
			if (steps_need > 0) begin
				newer_l = fl;
				newer_r = fr;
				if (steps_done + 1 < steps_need) begin
					psum_l += fl;
					psum_r += fr;
				end
				steps_done++;
				if (steps_done >= steps_need) begin
					close_frame(l, r);
					if (count < MAX_OUT_PER_IN)
						push_frame(count, l, r);
					run_frames(count);
				end
			end
		end
		if (count > 0)
			frames_due[$].last = 1'b1;
		return count;
	endfunction

	// Monitor: checks every accepted output frame, predicts every accepted request
	// and watches for a stalled run.
	always @(posedge clk) begin
		int     n;
		frame_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (frames_due.size() == 0) begin
					report("unexpected frame, left", left_out, 0);
				end else begin
					want = frames_due.pop_front();
					if (left_out !== want.left)
						report("left_out", left_out, $signed(want.left));
					if (right_out !== want.right)
						report("right_out", right_out, $signed(want.right));
					if (last_of_run !== want.last)
						report("last_of_run", last_of_run, want.last);
				end
			end
			if (in_valid && in_ready) begin
				n = predict_frames(first_channel_bytes, second_channel_bytes);
				// Rows with a typed answer also keep the predictor honest.
				if (row_has_exp) begin
					if (n != 1)
						report("typed row frame count", n, 1);
					else if (frames_due[$] !== row_exp)
						report("typed row left", $signed(frames_due[$].left),
							$signed(row_exp.left));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure per frame, calm stretches, and one long
	// hold-off that lets the converter fill up and refuse new requests.
	initial begin
		int  gap;
		bit  calm;
		bit  held;
		out_ready = 1'b0;
		calm = 1'b0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (results_seen % 50 == 49)
				calm = ($urandom_range(0, 2) == 0);
			gap = calm ? 0 : $urandom_range(0, 11);
			if (!held && results_seen >= 40) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Writes all seven registers on consecutive edges and mirrors them.
	task automatic write_regs(input longint v[7]);
		for (int i = 0; i < 7; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= v[i][15:0];
			case (CFG_IDX_W'(i))
				REG_STEP_WHOLE:    sh_whole = v[i] & 64'h7F;
				REG_STEP_NUM:      sh_num = v[i] & 64'hFFFF;
				REG_STEP_DEN:      sh_den = v[i] & 64'hFFFF;
				REG_WIDE:          sh_wide = v[i] & 64'h1;
				REG_UNSIGNED:      sh_uns = v[i] & 64'h1;
				REG_LITTLE_ENDIAN: sh_le = v[i] & 64'h1;
				REG_LAYOUT:        sh_layout = v[i] & 64'h3;
				default: ;
			endcase
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	// Stops offering, waits until every predicted frame is taken and the
	// converter is idle again, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0 || !in_ready)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offers one request after a random gap and returns at the edge that takes it.
	task automatic offer(input logic [15:0] a, input logic [15:0] b, input bit burst,
		input bit has_exp, input frame_t exp);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_channel_bytes <= a;
		second_channel_bytes <= b;
		row_has_exp <= has_exp;
		row_exp <= exp;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic frame_t mk(input logic [15:0] l, input logic [15:0] r);
		frame_t f;
		f.left = l;
		f.right = r;
		f.last = 1'b1;
		return f;
	endfunction

	initial begin
		plan_row_t plan[$];
		longint    cfg_sets[7][7];
		longint    v[7];
		int        cur_sel;
		int        per_phase;
		bit        burst;
		frame_t    none;

		none = '0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		first_channel_bytes = '0;
		second_channel_bytes = '0;
		row_has_exp = 1'b0;
		row_exp = '0;
		errors = 0;
		results_seen = 0;
		idle_cycles = 0;
		sh_whole = 1; sh_num = 0; sh_den = 1;
		sh_wide = 1; sh_uns = 0; sh_le = 1; sh_layout = LAYOUT_LR;
		older_l = 0; older_r = 0; newer_l = 0; newer_r = 0;
		psum_l = 0; psum_r = 0; frac_acc = 0; steps_need = 0; steps_done = 0;
		stream_primed = 1'b0;

		// Register sets: whole, num, den, wide, unsigned, little endian, layout.
		cfg_sets[0] = '{1, 0, 1, 1, 0, 1, 1};               // reset values
		cfg_sets[1] = '{0, 0, 1, 1, 0, 1, 1};               // zero ratio
		cfg_sets[2] = '{2, 1, 3, 0, 1, 0, 0};               // 8-bit unsigned mono
		cfg_sets[3] = '{0, 3, 7, 1, 1, 0, 2};               // upsampling, big endian, swapped
		cfg_sets[4] = '{127, 65535, 0, 1, 0, 0, 3};         // saturations, layout three
		cfg_sets[5] = '{64, 65534, 65535, 0, 0, 1, 1};      // largest ratio
		cfg_sets[6] = '{1, 9, 5, 1, 1, 1, 1};               // numerator above denominator

		// With the reset ratio of one, each frame comes out one request late.
		plan.push_back('{0, 16'h7FFF, 16'h8000, 1'b0, none});
		plan.push_back('{0, 16'h0000, 16'hFFFF, 1'b1, mk(16'h7FFF, 16'h8000)});
		plan.push_back('{0, 16'h1234, 16'h00FF, 1'b1, mk(16'h0000, 16'hFFFF)});
		plan.push_back('{0, 16'h8000, 16'h7FFF, 1'b1, mk(16'h1234, 16'h00FF)});
		plan.push_back('{1, 16'hFFFF, 16'h0000, 1'b0, none});
		plan.push_back('{1, 16'h0001, 16'h8000, 1'b0, none});
		plan.push_back('{2, 16'h00FF, 16'hFF00, 1'b0, none});
		plan.push_back('{2, 16'h0080, 16'h0000, 1'b0, none});
		plan.push_back('{2, 16'h007F, 16'hFFFF, 1'b0, none});
		plan.push_back('{2, 16'hFF00, 16'h00FF, 1'b0, none});
		plan.push_back('{2, 16'h0000, 16'h0080, 1'b0, none});
		plan.push_back('{3, 16'hFFFF, 16'h0000, 1'b0, none});
		plan.push_back('{3, 16'h00FF, 16'h8000, 1'b0, none});
		plan.push_back('{3, 16'h8000, 16'h00FF, 1'b0, none});
		plan.push_back('{3, 16'h7F7F, 16'h8080, 1'b0, none});
		plan.push_back('{4, 16'hAAAA, 16'h5555, 1'b0, none});
		plan.push_back('{4, 16'h5555, 16'hAAAA, 1'b0, none});
		plan.push_back('{4, 16'hFFFF, 16'hFFFF, 1'b0, none});
		plan.push_back('{5, 16'h8000, 16'h7FFF, 1'b0, none});
		plan.push_back('{5, 16'h7FFF, 16'h8000, 1'b0, none});
		plan.push_back('{6, 16'h0000, 16'hFFFF, 1'b0, none});
		plan.push_back('{6, 16'hFFFF, 16'h0000, 1'b0, none});
		plan.push_back('{6, 16'h8001, 16'h7FFE, 1'b0, none});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_sel = 0;
		foreach (plan[i]) begin
			if (plan[i].cfg_sel != cur_sel) begin
				drain();
				cur_sel = plan[i].cfg_sel;
				write_regs(cfg_sets[cur_sel]);
			end
			offer(plan[i].first, plan[i].second, 1'b0, plan[i].has_exp, plan[i].exp);
		end

		// Random phases: new registers each time, mostly modest ratios so that
		// frames come out often, now and then the saturating extremes.
		per_phase = RANDOM_ITEMS / RANDOM_PHASES;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			v[2] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 9);
			case ($urandom_range(0, 15))
				0:       v[0] = 0;
				15:      v[0] = $urandom_range(64, 127);
				default: v[0] = $urandom_range(1, 4);
			endcase
			if ($urandom_range(0, 7) == 0)
				v[1] = $urandom_range(0, 65535);
			else
				v[1] = $urandom_range(0, (v[2] > 0) ? v[2] - 1 : 0);
			// Keep the zero ratio, with its full bursts of frames, to the table.
			if (v[0] == 0 && (v[1] == 0 || v[2] <= 1))
				v[0] = 1;
			v[3] = $urandom_range(0, 1);
			v[4] = $urandom_range(0, 1);
			v[5] = $urandom_range(0, 1);
			v[6] = $urandom_range(0, 3);
			write_regs(v);
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < per_phase; i++)
				offer(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					burst, 1'b0, none);
		end

		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== linear_pcm_rate_converter.f =====
hdl/lpcm_pkg.sv
hdl/lpcm_div.sv
hdl/lpcm_dp.sv
hdl/lpcm_ctrl.sv
hdl/linear_pcm_rate_converter.sv
tb/sv/tb_linear_pcm_rate_converter.sv
